/* hdl/slcm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the set-associative LRU cache model.
package slcm_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int STAMP_WIDTH_DEF  = 32;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 62;
  localparam int TOTAL_W = 32;

  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;

  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
  localparam logic [WAYS_W-1:0]       WAYS_RST       = 4'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_IFETCH = 2'd3
  } mode_e;

  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_t;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    sat_inc = (v == '1) ? v : v + TOTAL_W'(1);
  endfunction

endpackage

/* hdl/slcm_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module slcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/slcm_way_select.sv */
`timescale 1ns / 1ps
// Tag match and LRU victim search across the ways of one set row.
module slcm_way_select #(
  parameter int MaxWays    = slcm_pkg::MAX_WAYS_DEF,
  parameter int StampWidth = slcm_pkg::STAMP_WIDTH_DEF,
  localparam int WayW      = (MaxWays > 1) ? $clog2(MaxWays) : 1
) (
  input  logic [MaxWays*slcm_pkg::TAG_W-1:0] tags_i,
  input  logic [MaxWays*StampWidth-1:0]      stamps_i,
  input  logic [slcm_pkg::TAG_W-1:0]         tag_i,
  input  logic [5:0]                         ways_i,
  output slcm_pkg::lookup_t                  lookup_o,
  output logic [WayW-1:0]                    way_o
);

  localparam int TagW = slcm_pkg::TAG_W;

  logic [MaxWays-1:0] in_use;
  logic [MaxWays-1:0] cand;
  logic               found;
  logic [WayW-1:0]    hit_way;
  logic [WayW-1:0]    victim_way;
  logic               victim_valid;

  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      in_use[w] = 6'(w) < ways_i;
    end
  end

  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    for (int w = 0; w < MaxWays; w++) begin
      if (!found && in_use[w] && (stamps_i[w*StampWidth +: StampWidth] != '0) &&
          (tags_i[w*TagW +: TagW] == tag_i)) begin
        found   = 1'b1;
        hit_way = WayW'(w);
      end
    end
  end

  // smallest stamp wins, ties go to the highest way
  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      cand[w] = in_use[w];
      for (int v = 0; v < MaxWays; v++) begin
        if (v < w && in_use[v]) begin
          cand[w] = cand[w] && (stamps_i[w*StampWidth +: StampWidth] <=
                                stamps_i[v*StampWidth +: StampWidth]);
        end else if (v > w && in_use[v]) begin
          cand[w] = cand[w] && (stamps_i[w*StampWidth +: StampWidth] <
                                stamps_i[v*StampWidth +: StampWidth]);
        end
      end
    end
  end

  always_comb begin
    victim_way   = '0;
    victim_valid = 1'b0;
    for (int w = 0; w < MaxWays; w++) begin
      if (cand[w]) begin
        victim_way   = victim_way | WayW'(w);
        victim_valid = victim_valid | (stamps_i[w*StampWidth +: StampWidth] != '0);
      end
    end
  end

  assign lookup_o.hit   = found;
  assign lookup_o.evict = !found && victim_valid;
  assign way_o          = found ? hit_way : victim_way;

endmodule

/* hdl/set_assoc_lru_cache_model_core.sv */
// Set-associative LRU cache model: top level with config, line RAMs and counters.
// A load, store or modify request is looked up after accept and its result is registered when the lookup completes.
// A new request is stalled until the read then write-back of the set row completes.
// Instruction fetch requests are accepted without a lookup and give no result.
// Reset: counters clear, time restarts at one, per-row valid bits clear so stamps read zero.
// No clearing pass runs over the line RAMs after reset.
`timescale 1ns / 1ps
module set_assoc_lru_cache_model_core #(
  parameter int MaxSetBits = slcm_pkg::MAX_SET_BITS_DEF,
  parameter int MaxWays    = slcm_pkg::MAX_WAYS_DEF,
  parameter int StampWidth = slcm_pkg::STAMP_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [slcm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [slcm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [slcm_pkg::ADDR_W-1:0]         address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                was_hit_o,
  output logic                                was_evicted_o,
  output logic                                second_hit_o,
  output logic [slcm_pkg::TOTAL_W-1:0]        hit_total_o,
  output logic [slcm_pkg::TOTAL_W-1:0]        miss_total_o,
  output logic [slcm_pkg::TOTAL_W-1:0]        eviction_total_o
);

  localparam int SetW    = MaxSetBits;
  localparam int Depth   = 1 << MaxSetBits;
  localparam int WayW    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int TagW    = slcm_pkg::TAG_W;
  localparam int TotW    = slcm_pkg::TOTAL_W;
  localparam int TagRowW = MaxWays * TagW;
  localparam int StRowW  = MaxWays * StampWidth;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q;

  logic [slcm_pkg::SET_BITS_W-1:0]   set_bits_q;
  logic [slcm_pkg::WAYS_W-1:0]       ways_q;
  logic [slcm_pkg::BLOCK_BITS_W-1:0] block_bits_q;

  logic                   in_acc;
  logic                   rd_en;
  logic                   done;
  logic [5:0]             blk_eff;
  logic [4:0]             set_eff;
  logic [5:0]             ways_eff;
  logic [SetW-1:0]        set_mask;
  logic [slcm_pkg::ADDR_W-1:0] addr_sh;
  logic [slcm_pkg::ADDR_W-1:0] tag_sh;
  logic [6:0]             tag_shift;
  logic [SetW-1:0]        set_d;
  logic [TagW-1:0]        tag_d;

  logic [SetW-1:0]        set_q;
  logic [TagW-1:0]        tag_q;
  slcm_pkg::mode_e        mode_q;

  logic [Depth-1:0]       row_valid_q;
  logic [TagRowW-1:0]     tag_rd;
  logic [StRowW-1:0]      st_rd;
  logic [StRowW-1:0]      st_row;
  logic [TagRowW-1:0]     tag_wr;
  logic [StRowW-1:0]      st_wr;

  slcm_pkg::lookup_t      lk;
  logic [WayW-1:0]        way;

  logic [StampWidth-1:0]  time_q;
  logic [StampWidth-1:0]  time_d;
  logic [TotW-1:0]        hits_q;
  logic [TotW-1:0]        hits_d;
  logic [TotW-1:0]        hits_first;
  logic [TotW-1:0]        misses_q;
  logic [TotW-1:0]        misses_d;
  logic [TotW-1:0]        evicts_q;
  logic [TotW-1:0]        evicts_d;

  logic                   out_valid_q;
  logic                   was_hit_q;
  logic                   was_evicted_q;
  logic                   second_hit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= slcm_pkg::SET_BITS_RST;
      ways_q       <= slcm_pkg::WAYS_RST;
      block_bits_q <= slcm_pkg::BLOCK_BITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        slcm_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_data_i[slcm_pkg::SET_BITS_W-1:0];
        slcm_pkg::CFG_WAYS:       ways_q       <= cfg_data_i[slcm_pkg::WAYS_W-1:0];
        slcm_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // address split
  always_comb begin
    blk_eff = (block_bits_q == '0) ? 6'd1 : block_bits_q;
    if (set_bits_q == '0) begin
      set_eff = 5'd1;
    end else if (32'(set_bits_q) > MaxSetBits) begin
      set_eff = 5'(MaxSetBits);
    end else begin
      set_eff = 5'(set_bits_q);
    end
    if (ways_q == '0) begin
      ways_eff = 6'd1;
    end else if (32'(ways_q) > MaxWays) begin
      ways_eff = 6'(MaxWays);
    end else begin
      ways_eff = 6'(ways_q);
    end
    for (int i = 0; i < SetW; i++) begin
      set_mask[i] = 5'(i) < set_eff;
    end
    addr_sh   = address_i >> blk_eff;
    set_d     = addr_sh[SetW-1:0] & set_mask;
    tag_shift = 7'(blk_eff) + 7'(set_eff);
    tag_sh    = address_i >> tag_shift;
    tag_d     = (tag_shift >= 7'd64) ? '0 : tag_sh[TagW-1:0];
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_en      = in_acc && (slcm_pkg::mode_e'(mode_i) != slcm_pkg::MODE_IFETCH);
  assign done       = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      set_q  <= set_d;
      tag_q  <= tag_d;
      mode_q <= slcm_pkg::mode_e'(mode_i);
    end
  end

  slcm_ram #(
    .Width (TagRowW),
    .Depth (Depth)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (done),
    .waddr_i (set_q),
    .wdata_i (tag_wr),
    .re_i    (rd_en),
    .raddr_i (set_d),
    .rdata_o (tag_rd)
  );

  slcm_ram #(
    .Width (StRowW),
    .Depth (Depth)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (done),
    .waddr_i (set_q),
    .wdata_i (st_wr),
    .re_i    (rd_en),
    .raddr_i (set_d),
    .rdata_o (st_rd)
  );

  assign st_row = row_valid_q[set_q] ? st_rd : '0;

  slcm_way_select #(
    .MaxWays    (MaxWays),
    .StampWidth (StampWidth)
  ) u_way_select (
    .tags_i   (tag_rd),
    .stamps_i (st_row),
    .tag_i    (tag_q),
    .ways_i   (ways_eff),
    .lookup_o (lk),
    .way_o    (way)
  );

  always_comb begin
    tag_wr = tag_rd;
    st_wr  = st_row;
    st_wr[way*StampWidth +: StampWidth] = time_q;
    if (!lk.hit) begin
      tag_wr[way*TagW +: TagW] = tag_q;
    end
  end

  always_comb begin
    hits_first = lk.hit ? slcm_pkg::sat_inc(hits_q) : hits_q;
    hits_d     = (mode_q == slcm_pkg::MODE_MODIFY) ? slcm_pkg::sat_inc(hits_first)
                                                   : hits_first;
    misses_d   = lk.hit ? misses_q : slcm_pkg::sat_inc(misses_q);
    evicts_d   = lk.evict ? slcm_pkg::sat_inc(evicts_q) : evicts_q;
    time_d     = (time_q == '1) ? time_q : time_q + StampWidth'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      was_hit_q     <= 1'b0;
      was_evicted_q <= 1'b0;
      second_hit_q  <= 1'b0;
      row_valid_q   <= '0;
      time_q        <= StampWidth'(1);
      hits_q        <= '0;
      misses_q      <= '0;
      evicts_q      <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (rd_en) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (done) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (done) begin
        out_valid_q         <= 1'b1;
        was_hit_q           <= lk.hit;
        was_evicted_q       <= lk.evict;
        second_hit_q        <= (mode_q == slcm_pkg::MODE_MODIFY);
        row_valid_q[set_q]  <= 1'b1;
        time_q              <= time_d;
        hits_q              <= hits_d;
        misses_q            <= misses_d;
        evicts_q            <= evicts_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign was_hit_o        = was_hit_q;
  assign was_evicted_o    = was_evicted_q;
  assign second_hit_o     = second_hit_q;
  assign hit_total_o      = hits_q;
  assign miss_total_o     = misses_q;
  assign eviction_total_o = evicts_q;

  a_lookup_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (state_q == ST_LOOKUP))
    else $error("lookup did not follow an accepted request");

  a_time_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q != '0)
    else $error("access time reached zero");

  a_miss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (misses_q >= $past(misses_q)))
    else $error("miss total decreased");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(was_hit_q && was_evicted_q))
    else $error("hit reported together with eviction");

  a_result_from_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_LOOKUP))
    else $error("result appeared without a lookup");

endmodule
